// File: sv/rmlp_pkg.sv
// ----------------------------------------------------------------------------
// rmlp_pkg
// Shared types and constants of the range median low-pass filter.
// ----------------------------------------------------------------------------
package rmlp_pkg;

  localparam int WINDOW_SIZE_DEF = 5;

  localparam int DIST_W  = 16;
  localparam int TIME_W  = 32;
  localparam int ALPHA_W = 9;
  localparam int SMOOTH_W = 24;
  localparam int FRAC_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // register indexes (word address)
  localparam logic [2:0] REG_MIN_DIST = 3'd0;
  localparam logic [2:0] REG_MAX_DIST = 3'd1;
  localparam logic [2:0] REG_INV_CODE = 3'd2;
  localparam logic [2:0] REG_STALE    = 3'd3;
  localparam logic [2:0] REG_ALPHA    = 3'd4;

  localparam logic [DIST_W-1:0]  MIN_DIST_RST = 16'd20;
  localparam logic [DIST_W-1:0]  MAX_DIST_RST = 16'd4500;
  localparam logic [DIST_W-1:0]  INV_CODE_RST = 16'hFFFF;
  localparam logic [DIST_W-1:0]  STALE_RST    = 16'd500;
  localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd77;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 9'd256;

  typedef struct packed {
    logic start;        // item accepted this cycle
    logic take_sample;  // store raw sample, time, pending
    logic clear;        // invalidate all filter state
    logic insert;       // write pending sample into the window
    logic med_step;     // test one median candidate
    logic mul;          // first blend product
    logic blend;        // second product, sum, update smoothed value
    logic load_out;     // fill the result register
  } cmd_t;

  typedef struct packed {
    logic is_eval;
    logic stale;
    logic pending;
    logic in_range;
    logic med_found;
  } status_t;

endpackage

// File: sv/rmlp_ctrl.sv
// ----------------------------------------------------------------------------
// rmlp_ctrl
// Sequencer of the filter: accepts one item, runs the median search and
// the blend on an update, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rmlp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  rmlp_pkg::status_t status,
  output rmlp_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    IDLE   = 5'b00001,
    MEDIAN = 5'b00010,
    MUL    = 5'b00100,
    BLEND  = 5'b01000,
    DONE   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;
  logic   out_free;

  assign item_stall = (state != IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (item_valid) begin
          cmd.start = 1'b1;
          state_next = DONE;
          if (!status.is_eval) begin
            cmd.take_sample = 1'b1;
          end else if (status.stale) begin
            cmd.clear = 1'b1;
          end else if (status.pending) begin
            if (status.in_range) begin
              cmd.insert = 1'b1;
              state_next = MEDIAN;
            end else begin
              cmd.clear = 1'b1;
            end
          end
        end
      end
      MEDIAN: begin
        cmd.med_step = 1'b1;
        if (status.med_found) begin
          state_next = MUL;
        end
      end
      MUL: begin
        cmd.mul = 1'b1;
        state_next = BLEND;
      end
      BLEND: begin
        cmd.blend = 1'b1;
        state_next = DONE;
      end
      DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.load_out) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

// File: sv/rmlp_dp.sv
// ----------------------------------------------------------------------------
// rmlp_dp
// Datapath: sample store, ring window, rank-count median search, Q16.8
// exponential low-pass and the result register.
// ----------------------------------------------------------------------------
module rmlp_dp #(
  parameter int WINDOW_SIZE = rmlp_pkg::WINDOW_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rmlp_pkg::cmd_t                cmd,
  output rmlp_pkg::status_t             status,
  input  logic                          req_type,
  input  logic [rmlp_pkg::DIST_W-1:0]   distance,
  input  logic [rmlp_pkg::TIME_W-1:0]   now_ms,
  input  logic [rmlp_pkg::DIST_W-1:0]   min_valid_distance,
  input  logic [rmlp_pkg::DIST_W-1:0]   max_valid_distance,
  input  logic [rmlp_pkg::DIST_W-1:0]   invalid_code,
  input  logic [rmlp_pkg::DIST_W-1:0]   stale_timeout_ms,
  input  logic [rmlp_pkg::ALPHA_W-1:0]  alpha_q8,
  output logic [rmlp_pkg::DIST_W-1:0]   filtered_distance,
  output logic                          data_pending,
  output logic                          was_invalidated
);

  localparam int IDX_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int DW     = rmlp_pkg::DIST_W;
  localparam int SW     = rmlp_pkg::SMOOTH_W;
  localparam int FW     = rmlp_pkg::FRAC_W;
  localparam int AW     = rmlp_pkg::ALPHA_W;
  localparam int PROD_W = AW + SW;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW_SIZE);

  logic [DW-1:0]     win [WINDOW_SIZE];
  logic [IDX_W-1:0]  write_slot;
  logic [CNT_W-1:0]  fill_count;
  logic [DW-1:0]     raw_sample;
  logic              pending_flag;
  logic [rmlp_pkg::TIME_W-1:0] sample_time;
  logic [SW-1:0]     smoothed;
  logic [DW-1:0]     output_value;
  logic              invalidated;
  logic [IDX_W-1:0]  cand;
  logic [DW-1:0]     median;
  logic [PROD_W-1:0] prod_new;

  logic [rmlp_pkg::TIME_W-1:0] age;
  logic [CNT_W-1:0]  less_cnt, leq_cnt, mid;
  logic [DW-1:0]     cand_val;
  logic [AW-1:0]     alpha_eff, alpha_rest;
  logic [PROD_W-1:0] prod_old;
  logic [PROD_W:0]   blend_sum;
  logic [SW-1:0]     smoothed_next;
  logic              fresh;

  // ---- evaluation decisions ----
  assign age = now_ms - sample_time;
  assign status.is_eval  = req_type;
  assign status.stale    = (sample_time == '0) || (age > {16'd0, stale_timeout_ms});
  assign status.pending  = pending_flag;
  assign status.in_range = (raw_sample >= min_valid_distance) &&
                           (raw_sample <= max_valid_distance) &&
                           (raw_sample != invalid_code);

  // ---- median: rank of one candidate against the filled entries ----
  assign cand_val = win[cand];
  assign mid      = fill_count >> 1;

  always_comb begin
    less_cnt = '0;
    leq_cnt  = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      if (CNT_W'(j) < fill_count) begin
        less_cnt = less_cnt + CNT_W'(win[j] <  cand_val);
        leq_cnt  = leq_cnt  + CNT_W'(win[j] <= cand_val);
      end
    end
  end

  // the candidate sits at the middle sorted position
  assign status.med_found = (less_cnt <= mid) && (mid < leq_cnt);

  // ---- blend ----
  assign alpha_eff  = (alpha_q8 > rmlp_pkg::ALPHA_ONE) ? rmlp_pkg::ALPHA_ONE : alpha_q8;
  assign alpha_rest = rmlp_pkg::ALPHA_ONE - alpha_eff;
  assign prod_old   = PROD_W'(alpha_rest) * PROD_W'(smoothed);
  assign blend_sum  = {1'b0, prod_new} + {1'b0, prod_old};
  assign fresh      = (fill_count <= CNT_W'(1)) || (output_value == invalid_code);
  assign smoothed_next = fresh ? {median, {FW{1'b0}}} : blend_sum[SW+FW-1:FW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win[i] <= rmlp_pkg::INV_CODE_RST;
      end
      write_slot   <= '0;
      fill_count   <= '0;
      raw_sample   <= rmlp_pkg::INV_CODE_RST;
      pending_flag <= 1'b0;
      sample_time  <= '0;
      smoothed     <= '0;
      output_value <= rmlp_pkg::INV_CODE_RST;
      invalidated  <= 1'b0;
      cand         <= '0;
    end else begin
      // a clear only ever comes with the accepting cycle
      if (cmd.start) begin
        invalidated <= cmd.clear;
      end
      if (cmd.take_sample) begin
        raw_sample   <= distance;
        pending_flag <= 1'b1;
        sample_time  <= now_ms;
      end
      if (cmd.clear) begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
          win[i] <= invalid_code;
        end
        write_slot   <= '0;
        fill_count   <= '0;
        raw_sample   <= invalid_code;
        pending_flag <= 1'b0;
        smoothed     <= '0;
        output_value <= invalid_code;
      end
      if (cmd.insert) begin
        win[write_slot] <= raw_sample;
        write_slot      <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
        if (fill_count < FULL_CNT) begin
          fill_count <= fill_count + 1'b1;
        end
        pending_flag <= 1'b0;
        cand         <= '0;
      end
      if (cmd.med_step) begin
        cand <= cand + 1'b1;
      end
      if (cmd.blend) begin
        smoothed     <= smoothed_next;
        output_value <= smoothed_next[SW-1:FW];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.med_step && status.med_found) begin
      median <= cand_val;
    end
    if (cmd.mul) begin
      prod_new <= PROD_W'(alpha_eff) * PROD_W'({median, {FW{1'b0}}});
    end
    if (cmd.load_out) begin
      filtered_distance <= output_value;
      data_pending      <= pending_flag;
      was_invalidated   <= invalidated;
    end
  end

endmodule

// File: sv/range_median_lowpass_filter.sv
// ----------------------------------------------------------------------------
// range_median_lowpass_filter
// Median-of-window range smoother with an exponential low-pass stage.
// ----------------------------------------------------------------------------
// One item in flight at a time. A sample item, or an evaluate item that
// invalidates or finds nothing pending, goes straight to the result state;
// one that updates the filter first runs the median search, which tests one
// window entry per cycle by rank counting and stops at the first entry whose
// rank is the middle one, and then the MUL and BLEND steps form the blend. A
// finished result waits in an output register while the next item is taken.
// Configuration is written through the APB port at byte address 4*index and
// read back the same way.
// ----------------------------------------------------------------------------
module range_median_lowpass_filter #(
  parameter int WINDOW_SIZE = rmlp_pkg::WINDOW_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmlp_pkg::ADDR_W-1:0]   paddr,
  input  logic [rmlp_pkg::DATA_W-1:0]   pwdata,
  output logic [rmlp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          req_type,
  input  logic [rmlp_pkg::DIST_W-1:0]   distance,
  input  logic [rmlp_pkg::TIME_W-1:0]   now_ms,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [rmlp_pkg::DIST_W-1:0]   filtered_distance,
  output logic                          data_pending,
  output logic                          was_invalidated
);

  logic [rmlp_pkg::DIST_W-1:0]  min_valid_distance;
  logic [rmlp_pkg::DIST_W-1:0]  max_valid_distance;
  logic [rmlp_pkg::DIST_W-1:0]  invalid_code;
  logic [rmlp_pkg::DIST_W-1:0]  stale_timeout_ms;
  logic [rmlp_pkg::ALPHA_W-1:0] alpha_q8;
  logic [2:0]                   reg_idx;
  logic                         wr_en;

  rmlp_pkg::cmd_t    cmd;
  rmlp_pkg::status_t status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid_distance <= rmlp_pkg::MIN_DIST_RST;
      max_valid_distance <= rmlp_pkg::MAX_DIST_RST;
      invalid_code       <= rmlp_pkg::INV_CODE_RST;
      stale_timeout_ms   <= rmlp_pkg::STALE_RST;
      alpha_q8           <= rmlp_pkg::ALPHA_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        rmlp_pkg::REG_MIN_DIST: min_valid_distance <= pwdata[15:0];
        rmlp_pkg::REG_MAX_DIST: max_valid_distance <= pwdata[15:0];
        rmlp_pkg::REG_INV_CODE: invalid_code       <= pwdata[15:0];
        rmlp_pkg::REG_STALE:    stale_timeout_ms   <= pwdata[15:0];
        rmlp_pkg::REG_ALPHA:    alpha_q8           <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rmlp_pkg::REG_MIN_DIST: prdata = {16'd0, min_valid_distance};
      rmlp_pkg::REG_MAX_DIST: prdata = {16'd0, max_valid_distance};
      rmlp_pkg::REG_INV_CODE: prdata = {16'd0, invalid_code};
      rmlp_pkg::REG_STALE:    prdata = {16'd0, stale_timeout_ms};
      rmlp_pkg::REG_ALPHA:    prdata = {23'd0, alpha_q8};
      default:                prdata = '0;
    endcase
  end

  rmlp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  rmlp_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .req_type           (req_type),
    .distance           (distance),
    .now_ms             (now_ms),
    .min_valid_distance (min_valid_distance),
    .max_valid_distance (max_valid_distance),
    .invalid_code       (invalid_code),
    .stale_timeout_ms   (stale_timeout_ms),
    .alpha_q8           (alpha_q8),
    .filtered_distance  (filtered_distance),
    .data_pending       (data_pending),
    .was_invalidated    (was_invalidated)
  );

endmodule

// File: tb/tb_range_median_lowpass_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_median_lowpass_filter
// Self-checking bench for the median window and low-pass range smoother.
// A short directed table covers the freshness, range and wrap cases, then
// random sample/evaluate sequences run under several register settings.
// Each result is checked against the table entry or an in-bench filter model,
// with random gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_range_median_lowpass_filter;

  localparam int WIN         = rmlp_pkg::WINDOW_SIZE_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 130;
  localparam int REPORT_MAX  = 100;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_EVAL   = 1'b1;

  typedef struct packed {
    logic [rmlp_pkg::DIST_W-1:0] dval;
    logic                        pend;
    logic                        inv;
  } reading_t;

  typedef struct packed {
    logic                        rq;
    logic [rmlp_pkg::DIST_W-1:0] din;
    logic [rmlp_pkg::TIME_W-1:0] t;
    logic                        chk;
    reading_t                    want;
  } dir_row_t;

  typedef struct {
    logic [rmlp_pkg::DIST_W-1:0]  lo;
    logic [rmlp_pkg::DIST_W-1:0]  hi;
    logic [rmlp_pkg::DIST_W-1:0]  code;
    logic [rmlp_pkg::DIST_W-1:0]  stale;
    logic [rmlp_pkg::ALPHA_W-1:0] alpha;
  } setup_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [rmlp_pkg::ADDR_W-1:0]   paddr = '0;
  logic [rmlp_pkg::DATA_W-1:0]   pwdata = '0;
  logic [rmlp_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          item_valid = 1'b0;
  logic                          item_stall;
  logic                          req_type = 1'b0;
  logic [rmlp_pkg::DIST_W-1:0]   distance = '0;
  logic [rmlp_pkg::TIME_W-1:0]   now_ms = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [rmlp_pkg::DIST_W-1:0]   filtered_distance;
  logic                          data_pending;
  logic                          was_invalidated;

  // filter model: register copies and state
  logic [rmlp_pkg::DIST_W-1:0]   lo_lim, hi_lim, no_read, stale_lim;
  logic [rmlp_pkg::ALPHA_W-1:0]  alpha;
  logic [rmlp_pkg::DIST_W-1:0]   win [WIN];
  int                            slot, fill;
  logic [rmlp_pkg::DIST_W-1:0]   raw;
  logic                          pend;
  logic [rmlp_pkg::TIME_W-1:0]   stamp;
  logic [rmlp_pkg::SMOOTH_W-1:0] smooth;
  logic [rmlp_pkg::DIST_W-1:0]   held;

  reading_t filtered_q [$];
  reading_t want;
  int       fails = 0;
  int       stall_run = 0;
  bit       idle_on = 1'b1;
  logic [rmlp_pkg::TIME_W-1:0] cur_ms;

  // freshness, range limits, even median, wrap of the ms counter
  dir_row_t dir_tab [25] = '{
    '{REQ_EVAL,   16'd0,     32'd100,        1'b1, '{16'hFFFF, 1'b0, 1'b1}},
    '{REQ_SAMPLE, 16'd1000,  32'd0,          1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd10,         1'b1, '{16'hFFFF, 1'b0, 1'b1}},
    '{REQ_SAMPLE, 16'd1000,  32'd1000,       1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd1100,       1'b1, '{16'd1000, 1'b0, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd1200,       1'b1, '{16'd1000, 1'b0, 1'b0}},
    '{REQ_SAMPLE, 16'd2000,  32'd1300,       1'b1, '{16'd1000, 1'b1, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd1350,       1'b0, '{16'd0,    1'b0, 1'b0}},
    '{REQ_SAMPLE, 16'd19,    32'd1400,       1'b0, '{16'd0,    1'b0, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd1450,       1'b1, '{16'hFFFF, 1'b0, 1'b1}},
    '{REQ_SAMPLE, 16'd4500,  32'd1500,       1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd1500,       1'b1, '{16'd4500, 1'b0, 1'b0}},
    '{REQ_SAMPLE, 16'd20,    32'd1600,       1'b0, '{16'd0,    1'b0, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd2100,       1'b0, '{16'd0,    1'b0, 1'b0}},
    '{REQ_SAMPLE, 16'd4501,  32'd2200,       1'b0, '{16'd0,    1'b0, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd2200,       1'b1, '{16'hFFFF, 1'b0, 1'b1}},
    '{REQ_SAMPLE, 16'd65535, 32'd2300,       1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd2300,       1'b1, '{16'hFFFF, 1'b0, 1'b1}},
    '{REQ_SAMPLE, 16'd100,   32'd3000,       1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'd3501,       1'b1, '{16'hFFFF, 1'b0, 1'b1}},
    '{REQ_SAMPLE, 16'd300,   32'hFFFF_FF00,  1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'h0000_0010,  1'b1, '{16'd300,  1'b0, 1'b0}},
    '{REQ_SAMPLE, 16'd500,   32'h0000_0080,  1'b0, '{16'd0,    1'b0, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'h0000_0090,  1'b0, '{16'd0,    1'b0, 1'b0}},
    '{REQ_EVAL,   16'd0,     32'hFFFF_FFFF,  1'b1, '{16'hFFFF, 1'b0, 1'b1}}
  };

  range_median_lowpass_filter #(.WINDOW_SIZE(WIN)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .req_type(req_type), .distance(distance), .now_ms(now_ms),
    .result_valid(result_valid), .result_stall(result_stall),
    .filtered_distance(filtered_distance), .data_pending(data_pending),
    .was_invalidated(was_invalidated)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic clear_filter();
    for (int i = 0; i < WIN; i++) win[i] = no_read;
    slot = 0;
    fill = 0;
    raw = no_read;
    pend = 1'b0;
    smooth = '0;
    held = no_read;
  endtask

  task automatic filter_reset();
    lo_lim = rmlp_pkg::MIN_DIST_RST;
    hi_lim = rmlp_pkg::MAX_DIST_RST;
    no_read = rmlp_pkg::INV_CODE_RST;
    stale_lim = rmlp_pkg::STALE_RST;
    alpha = rmlp_pkg::ALPHA_RST;
    clear_filter();
    stamp = '0;
  endtask

  // median of the filled entries; upper middle for an even count
  function automatic logic [rmlp_pkg::DIST_W-1:0] window_median();
    logic [rmlp_pkg::DIST_W-1:0] tmp [WIN];
    logic [rmlp_pkg::DIST_W-1:0] v;
    int j;
    tmp = win;
    for (int i = 1; i < fill; i++) begin
      v = tmp[i];
      j = i;
      while (j > 0 && tmp[j-1] > v) begin
        tmp[j] = tmp[j-1];
        j--;
      end
      tmp[j] = v;
    end
    return tmp[fill/2];
  endfunction

  task automatic filter_step(input logic rq, input logic [rmlp_pkg::DIST_W-1:0] d,
                             input logic [rmlp_pkg::TIME_W-1:0] t, output reading_t r);
    logic [rmlp_pkg::TIME_W-1:0] age;
    logic [rmlp_pkg::DIST_W-1:0] med;
    logic [63:0]                 acc;
    int                          a;
    logic                        inv;
    inv = 1'b0;
    age = t - stamp;
    if (rq == REQ_SAMPLE) begin
      raw = d;
      pend = 1'b1;
      stamp = t;
    end else if (stamp == '0 || age > rmlp_pkg::TIME_W'(stale_lim)) begin
      clear_filter();
      inv = 1'b1;
    end else if (pend) begin
      pend = 1'b0;
      if (raw >= lo_lim && raw <= hi_lim && raw != no_read) begin
        win[slot] = raw;
        slot = (slot + 1) % WIN;
        if (fill < WIN) fill++;
        med = window_median();
        if (fill <= 1 || held == no_read) begin
          smooth = {med, 8'h00};
        end else begin
          a = (alpha > rmlp_pkg::ALPHA_ONE) ? 256 : int'(alpha);
          acc = (64'(a) * 64'({med, 8'h00}) + 64'(256 - a) * 64'(smooth))
                >> rmlp_pkg::FRAC_W;
          smooth = acc[rmlp_pkg::SMOOTH_W-1:0];
        end
        held = smooth[rmlp_pkg::SMOOTH_W-1:rmlp_pkg::FRAC_W];
      end else begin
        clear_filter();
        inv = 1'b1;
      end
    end
    r = '{held, pend, inv};
  endtask

  task automatic apb_write(input logic [2:0] idx,
                           input logic [rmlp_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      rmlp_pkg::REG_MIN_DIST: lo_lim = val[rmlp_pkg::DIST_W-1:0];
      rmlp_pkg::REG_MAX_DIST: hi_lim = val[rmlp_pkg::DIST_W-1:0];
      rmlp_pkg::REG_INV_CODE: no_read = val[rmlp_pkg::DIST_W-1:0];
      rmlp_pkg::REG_STALE:    stale_lim = val[rmlp_pkg::DIST_W-1:0];
      rmlp_pkg::REG_ALPHA:    alpha = val[rmlp_pkg::ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input setup_t s);
    apb_write(rmlp_pkg::REG_MIN_DIST, rmlp_pkg::DATA_W'(s.lo));
    apb_write(rmlp_pkg::REG_MAX_DIST, rmlp_pkg::DATA_W'(s.hi));
    apb_write(rmlp_pkg::REG_INV_CODE, rmlp_pkg::DATA_W'(s.code));
    apb_write(rmlp_pkg::REG_STALE, rmlp_pkg::DATA_W'(s.stale));
    apb_write(rmlp_pkg::REG_ALPHA, rmlp_pkg::DATA_W'(s.alpha));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_item(input logic rq, input logic [rmlp_pkg::DIST_W-1:0] d,
                           input logic [rmlp_pkg::TIME_W-1:0] t, input logic typed,
                           input reading_t typed_val);
    int gap;
    reading_t r;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    req_type <= rq;
    distance <= d;
    now_ms <= t;
    do @(posedge clk); while (item_stall !== 1'b0);
    filter_step(rq, d, t, r);
    filtered_q.push_back(typed ? typed_val : r);
  endtask

  // block holds one item at a time; let it go quiet before touching registers
  task automatic settle();
    item_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (WIN + 8) @(posedge clk);
  endtask

  function automatic logic [rmlp_pkg::DIST_W-1:0] pick_dist();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && lo_lim <= hi_lim)
      return rmlp_pkg::DIST_W'($urandom_range(lo_lim, hi_lim));
    if (r < 78) return no_read;
    if (r < 88) return rmlp_pkg::DIST_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return lo_lim - 1'b1;
      default: return hi_lim + 1'b1;
    endcase
  endfunction

  function automatic logic [rmlp_pkg::TIME_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return rmlp_pkg::TIME_W'($urandom_range(0, stale_lim));
    if (r < 88) return '0;
    if (r < 94)
      return rmlp_pkg::TIME_W'(stale_lim) + 1 + rmlp_pkg::TIME_W'($urandom_range(0, 40));
    return rmlp_pkg::TIME_W'($urandom());
  endfunction

  task automatic run_random(input int count);
    int n;
    int r;
    n = 0;
    cur_ms = rmlp_pkg::TIME_W'($urandom());
    while (n < count) begin
      if ($urandom_range(0, 99) < 3) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        push_item(REQ_SAMPLE, pick_dist(), cur_ms, 1'b0, '0);
        cur_ms += pick_step();
        push_item(REQ_EVAL, rmlp_pkg::DIST_W'($urandom_range(0, 65535)), cur_ms, 1'b0,
                  '0);
        n += 2;
        if ($urandom_range(0, 4) == 0) begin
          cur_ms += pick_step();
          push_item(REQ_EVAL, rmlp_pkg::DIST_W'($urandom_range(0, 65535)), cur_ms,
                    1'b0, '0);
          n++;
        end
      end else if (r < 87) begin
        cur_ms += pick_step();
        push_item(REQ_EVAL, rmlp_pkg::DIST_W'($urandom_range(0, 65535)), cur_ms, 1'b0,
                  '0);
        n++;
      end else if (r < 95) begin
        // lone sample, which a later sample may overwrite before it is evaluated
        push_item(REQ_SAMPLE, pick_dist(), cur_ms, 1'b0, '0);
        n++;
      end else begin
        cur_ms = rmlp_pkg::TIME_W'($urandom());
      end
    end
  endtask

  // result side: random stall runs and the check against the expected readings
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        if (filtered_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX) $error("result item with no input item outstanding");
        end else begin
          want = filtered_q.pop_front();
          if (filtered_distance !== want.dval) begin
            fails++;
            if (fails <= REPORT_MAX)
              $error("filtered_distance: expected %0d, got %0d", want.dval,
                     filtered_distance);
          end
          if (data_pending !== want.pend) begin
            fails++;
            if (fails <= REPORT_MAX)
              $error("data_pending: expected %0d, got %0d", want.pend, data_pending);
          end
          if (was_invalidated !== want.inv) begin
            fails++;
            if (fails <= REPORT_MAX)
              $error("was_invalidated: expected %0d, got %0d", want.inv,
                     was_invalidated);
          end
        end
      end
      if (stall_run > 0) begin
        stall_run--;
        result_stall <= 1'b1;
      end else begin
        stall_run = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        result_stall <= (stall_run > 0);
        if (stall_run > 0) stall_run--;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && item_stall === 1'b0) ||
          (result_valid === 1'b1 && !result_stall) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : main
    setup_t s;
    filter_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < $size(dir_tab); k++)
      push_item(dir_tab[k].rq, dir_tab[k].din, dir_tab[k].t, dir_tab[k].chk,
                dir_tab[k].want);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: s = '{16'd0, 16'd65535, 16'd65535, 16'd65535, 9'd256};
        1: s = '{16'd0, 16'd65535, 16'd0, 16'd0, 9'd0};
        2: s = '{16'd100, 16'd60000, 16'd30000, 16'd1000, 9'd511};
        3: s = '{16'd5000, 16'd100, 16'd12345, 16'd200, 9'd128};  // empty range
        default: begin
          s.lo = rmlp_pkg::DIST_W'($urandom_range(0, 4000));
          s.hi = s.lo + rmlp_pkg::DIST_W'($urandom_range(0, 20000));
          s.code = rmlp_pkg::DIST_W'($urandom_range(0, 65535));
          s.stale = rmlp_pkg::DIST_W'($urandom_range(1, 3000));
          s.alpha = rmlp_pkg::ALPHA_W'($urandom_range(0, 300));
        end
      endcase
      set_filter(s);
      idle_on = (p != 2);
      run_random(PHASE_ITEMS);
      settle();
    end

    if (fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
